[rtl/core/assert_macros.svh]
// Assertion helpers used by the RTL datapath (uct_dp).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds on a rising clock edge while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/uct_pkg.sv]
package uct_pkg;
  localparam int MaxChildren = 64;
  localparam int FracBits    = 16;
  localparam int IdxW        = 6;
  localparam int CntW        = 7;
  localparam int ScoreW      = FracBits + 3;
  localparam int FieldW      = 24;
  localparam int LogW        = 5 + FracBits;
  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};
  localparam logic [32:0] TwoLn2Q32 = 33'd5954088944;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DIV  = 9'b000000010,
    ST_LOGP = 9'b000000100,
    ST_LOGV = 9'b000001000,
    ST_MUL  = 9'b000010000,
    ST_SQRT = 9'b000100000,
    ST_CMP  = 9'b001000000,
    ST_OUT  = 9'b010000000,
    ST_WAIT = 9'b100000000
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic log_init_p;
    logic log_init_v;
    logic log_step;
    logic log_save_p;
    logic mul;
    logic sqrt_init;
    logic sqrt_step;
    logic update;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic       step_done;
    logic       last;
    logic       zero_visits;
    logic       need_explore;
  } status_t;
endpackage

[rtl/core/uct_ctrl.sv]
module uct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  uct_pkg::status_t  sts,
  output uct_pkg::cmd_t     cmd
);
  uct_pkg::state_t state_r, state_nxt;

  assign in_stall  = (state_r != uct_pkg::ST_IDLE);
  assign out_valid = (state_r == uct_pkg::ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      uct_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = uct_pkg::ST_DIV;
        end
      end
      uct_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_done) begin
          if (sts.zero_visits || !sts.need_explore) begin
            state_nxt = uct_pkg::ST_CMP;
          end else begin
            cmd.log_init_p = 1'b1;
            state_nxt = uct_pkg::ST_LOGP;
          end
        end
      end
      uct_pkg::ST_LOGP: begin
        cmd.log_step = 1'b1;
        if (sts.step_done) begin
          cmd.log_save_p = 1'b1;
          cmd.log_init_v = 1'b1;
          state_nxt = uct_pkg::ST_LOGV;
        end
      end
      uct_pkg::ST_LOGV: begin
        cmd.log_step = 1'b1;
        if (sts.step_done) state_nxt = uct_pkg::ST_MUL;
      end
      uct_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.sqrt_init = 1'b1;
        state_nxt = uct_pkg::ST_SQRT;
      end
      uct_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_done) state_nxt = uct_pkg::ST_CMP;
      end
      uct_pkg::ST_CMP: begin
        cmd.update = 1'b1;
        state_nxt = sts.last ? uct_pkg::ST_OUT : uct_pkg::ST_IDLE;
      end
      uct_pkg::ST_OUT: begin
        if (!out_stall) begin
          cmd.clear = 1'b1;
          state_nxt = uct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = uct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= uct_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

[rtl/core/uct_dp.sv]
`include "assert_macros.svh"
module uct_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [uct_pkg::FieldW-1:0]     in_child_wins,
  input  logic [uct_pkg::FieldW-1:0]     in_child_visits,
  input  logic [uct_pkg::FieldW-1:0]     in_parent_visits,
  input  logic                           in_last_child,
  input  uct_pkg::cmd_t                  cmd,
  output uct_pkg::status_t               sts,
  output logic [uct_pkg::IdxW-1:0]       out_selected_index,
  output logic [uct_pkg::ScoreW-1:0]     out_best_score
);
  localparam int NumW = uct_pkg::FieldW + uct_pkg::FracBits;
  localparam int RemW = uct_pkg::FieldW + 1;
  localparam int TW   = uct_pkg::LogW + 1;
  localparam int RadW = 2 * TW + 2;

  logic [uct_pkg::FieldW-1:0] visits_r, parent_r;
  logic                       last_r;
  logic [NumW-1:0]            quo_r, quo_nxt;
  logic [RemW-1:0]            rem_r, rem_nxt;
  logic [5:0]                 cnt_r;
  logic [31:0]                m_r;
  logic [uct_pkg::FracBits-1:0] frac_r;
  logic [4:0]                 top_r;
  logic [uct_pkg::LogW-1:0]   logp_r;
  logic [RadW-1:0]            sv_r, res_r, bit_r;
  logic [uct_pkg::ScoreW-1:0] best_r;
  logic [uct_pkg::IdxW-1:0]   bpos_r;
  logic [uct_pkg::CntW-1:0]   pos_r;
  logic                       have_r;

  logic [RemW-1:0]            rem_sh;
  logic [63:0]                sq;
  logic [32:0]                msq;
  logic [uct_pkg::FieldW-1:0] lx;
  logic [4:0]                 ltop;
  logic [uct_pkg::LogW-1:0]   logv, diff;
  logic [uct_pkg::LogW+33-1:0] prod;
  logic [RadW-1:0]            trial;
  logic [uct_pkg::ScoreW+1:0] sum;
  logic [uct_pkg::ScoreW-1:0] score;

  always_comb begin
    rem_sh  = {rem_r[RemW-2:0], quo_r[NumW-1]};
    quo_nxt = {quo_r[NumW-2:0], 1'b0};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, visits_r}) begin
      rem_nxt = rem_sh - {1'b0, visits_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_comb begin
    lx = cmd.log_init_p ? parent_r : visits_r;
    ltop = '0;
    for (int i = 0; i < uct_pkg::FieldW; i++) begin
      if (lx[i]) ltop = 5'(i);
    end
  end

  assign sq   = {32'd0, m_r} * {32'd0, m_r};
  assign msq  = sq[62:30];
  assign logv = {top_r, frac_r};
  assign diff = logp_r - logv;
  assign prod = {33'd0, diff} * {{uct_pkg::LogW{1'b0}}, uct_pkg::TwoLn2Q32};
  assign trial = res_r + bit_r;

  always_comb begin
    sum = {2'b00, quo_r[uct_pkg::ScoreW-1:0]} + {2'b00, res_r[uct_pkg::ScoreW-1:0]};
    if (visits_r == '0) score = uct_pkg::ScoreMax;
    else if (quo_r[NumW-1:uct_pkg::ScoreW] != '0 || res_r[RadW-1:uct_pkg::ScoreW] != '0
             || sum > {2'b00, uct_pkg::ScoreMax})
      score = uct_pkg::ScoreMax;
    else score = sum[uct_pkg::ScoreW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r <= 6'(NumW - 1);
    end else if (cmd.log_init_p || cmd.log_init_v) begin
      cnt_r <= 6'(uct_pkg::FracBits - 1);
    end else if (cmd.mul) begin
      cnt_r <= 6'(RadW / 2 - 1);
    end else if (cmd.div_step || cmd.log_step || cmd.sqrt_step) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      visits_r <= in_child_visits;
      parent_r <= in_parent_visits;
      last_r   <= in_last_child;
      quo_r    <= {in_child_wins, {uct_pkg::FracBits{1'b0}}};
      rem_r    <= '0;
      res_r    <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.log_init_p || cmd.log_init_v) begin
      top_r  <= ltop;
      m_r    <= 32'({lx, 7'd0} << (5'd23 - ltop));
      frac_r <= '0;
    end else if (cmd.log_step) begin
      frac_r <= {frac_r[uct_pkg::FracBits-2:0], msq[31]};
      m_r    <= msq[31] ? msq[32:1] : msq[31:0];
    end
    if (cmd.log_save_p) logp_r <= {top_r, frac_r[uct_pkg::FracBits-2:0], msq[31]};
    if (cmd.sqrt_init) begin
      sv_r  <= {{(RadW-TW-uct_pkg::FracBits){1'b0}}, prod[32 +: TW],
                {uct_pkg::FracBits{1'b0}}};
      res_r <= '0;
      bit_r <= {2'b01, {(RadW-2){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (sv_r >= trial) begin
        sv_r  <= sv_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      best_r <= '0;
      bpos_r <= '0;
      pos_r  <= '0;
      have_r <= 1'b0;
    end else if (cmd.update && pos_r < uct_pkg::CntW'(uct_pkg::MaxChildren)) begin
      if (!have_r || score > best_r) begin
        best_r <= score;
        bpos_r <= pos_r[uct_pkg::IdxW-1:0];
        have_r <= 1'b1;
      end
      pos_r <= pos_r + uct_pkg::CntW'(1);
    end
  end

  assign sts.step_done    = (cnt_r == '0);
  assign sts.last         = last_r;
  assign sts.zero_visits  = (visits_r == '0);
  assign sts.need_explore = (parent_r > visits_r);

  assign out_selected_index = bpos_r;
  assign out_best_score     = best_r;

  `ASSERT_CLK(a_pos_cap, clk, rst_n, pos_r <= uct_pkg::CntW'(uct_pkg::MaxChildren),
    "child count beyond cap")
  `ASSERT_CLK(a_clear, clk, rst_n, cmd.clear |=> (pos_r == '0 && !have_r),
    "state not cleared")
  `ASSERT_CLK(a_have, clk, rst_n, (pos_r != '0) |-> have_r, "count without best")
  `ASSERT_NEVER(a_bpos_seen, clk, rst_n, have_r && {1'b0, bpos_r} >= pos_r,
    "best index beyond count")
endmodule

[rtl/core/uct_child_select_top.sv]
// An accepted child runs the divider, then goes to the compare if the explore term is
//   skipped (zero visits or parent not above child), else via log2 of parent and child,
//   the multiply and the sqrt; on the last child out_valid holds while out_stall is set.
//   One child at a time (in_stall); 40-step divide, 16-step log2 twice, 23-step sqrt.
// Reset: synchronous active-low rst_n clears the controller and selection state.
module uct_child_select_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [uct_pkg::FieldW-1:0]    in_child_wins,
  input  logic [uct_pkg::FieldW-1:0]    in_child_visits,
  input  logic [uct_pkg::FieldW-1:0]    in_parent_visits,
  input  logic                          in_last_child,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [uct_pkg::IdxW-1:0]      out_selected_index,
  output logic [uct_pkg::ScoreW-1:0]    out_best_score
);
  uct_pkg::cmd_t    cmd;
  uct_pkg::status_t sts;

  uct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  uct_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_child_wins(in_child_wins),
    .in_child_visits(in_child_visits), .in_parent_visits(in_parent_visits),
    .in_last_child(in_last_child), .cmd(cmd), .sts(sts),
    .out_selected_index(out_selected_index), .out_best_score(out_best_score)
  );
endmodule
